// ----- rtl/core/cescd_pkg.sv -----
// Shared types, character codes and helpers of the C escape decoder.
`timescale 1ns / 1ps
package cescd_pkg;

  // One input item: a byte of the escaped string and its end mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  // One result item: a decoded byte, or only the end mark.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_string;
  } out_item_t;

  // Command handed from the front part to the back part. A command carries at
  // most one code point (emitted first) and at most one raw byte (emitted after).
  typedef struct packed {
    logic        code_valid;
    logic        code_small;  // value must be below 0x80, else U+FFFD
    logic [31:0] code_value;
    logic        tail_valid;
    logic [7:0]  tail_byte;
    logic        last;
  } cmd_t;

  // Parser modes, one-hot.
  typedef enum logic [5:0] {
    ModeText = 6'b000001,
    ModeEsc  = 6'b000010,
    ModeOct  = 6'b000100,
    ModeHex  = 6'b001000,
    ModeU4   = 6'b010000,
    ModeU8   = 6'b100000
  } mode_e;

  localparam int unsigned CmdQueueDepth = 2;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChA         = 8'h61;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChV         = 8'h76;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChUpperU    = 8'h55;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperF    = 8'h46;

  localparam logic [7:0] CtlBell     = 8'h07;
  localparam logic [7:0] CtlBack     = 8'h08;
  localparam logic [7:0] CtlFeed     = 8'h0C;
  localparam logic [7:0] CtlNewline  = 8'h0A;
  localparam logic [7:0] CtlReturn   = 8'h0D;
  localparam logic [7:0] CtlTab      = 8'h09;
  localparam logic [7:0] CtlVtab     = 8'h0B;

  localparam logic [3:0] OctDigits   = 4'd3;
  localparam logic [3:0] U4Digits    = 4'd4;
  localparam logic [3:0] U8Digits    = 4'd8;
  localparam logic [3:0] MaxHexCount = 4'd15;

  localparam logic [20:0] Replacement = 21'h00FFFD;
  localparam logic [31:0] MaxCode     = 32'h0010FFFF;

  // Returns {valid, value} for a hex digit character.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= ChZero && c <= ChNine) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= ChA && c <= ChF) || (c >= ChUpperA && c <= ChUpperF)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/c_escape_decoder.sv -----
// Top level of the C escape decoder: front parser, command queue and byte emitter.
`timescale 1ns / 1ps
//  channel   direction  handshake             payload
//  input     in         push / full           in_item_i  (in_byte, end_of_string)
//  result    out        pop / empty           out_item_o (out_byte, has_byte, last_of_string)
//
//  The front part takes one item per cycle whenever the two-entry command queue has room.
//  An item's results reach the result ports through the command queue and the back part's sequence register.
//  Each item yields zero to four result items; the back part emits one per cycle while the
//  result side pops, and an item's count of results is set by its UTF-8 length and raw byte.
//  Reset (rst_ni low) returns the parser to plain text and empties the queue and output.
//  With the result side stalled, full rises once two commands wait behind the one emitted.
module c_escape_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  cescd_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output cescd_pkg::out_item_t out_item_o
);

  logic            accept;
  logic            enq;
  cescd_pkg::cmd_t cmd_in, cmd_out;
  logic            q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push & ~q_full;

  cescd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .enq_o    (enq),
    .cmd_o    (cmd_in)
  );

  cescd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (cmd_out),
    .empty_o (q_empty)
  );

  cescd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (~q_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

endmodule

// ----- rtl/core/cescd_front.sv -----
// Front part: parses escape sequences and issues byte and code point commands.
`timescale 1ns / 1ps
module cescd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  cescd_pkg::in_item_t item_i,
  output logic               enq_o,
  output cescd_pkg::cmd_t    cmd_o
);

  cescd_pkg::mode_e mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        allhex_q, allhex_d;

  logic [7:0]  c;
  logic [4:0]  hexd;
  logic        is_oct;
  logic        do_text;
  logic [31:0] acc_n;
  logic [3:0]  cnt_n;
  logic        allhex_n;

  assign c      = item_i.in_byte;
  assign hexd   = cescd_pkg::hex_decode(c);
  assign is_oct = (c >= cescd_pkg::ChZero) && (c <= cescd_pkg::ChSeven);

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    allhex_d = allhex_q;
    do_text  = 1'b0;
    acc_n    = acc_q;
    cnt_n    = cnt_q + 4'd1;
    allhex_n = allhex_q;
    cmd_o.code_valid = 1'b0;
    cmd_o.code_small = 1'b0;
    cmd_o.code_value = acc_q;
    cmd_o.tail_valid = 1'b0;
    cmd_o.tail_byte  = c;
    cmd_o.last       = item_i.end_of_string;

    unique case (mode_q)
      cescd_pkg::ModeEsc: begin
        mode_d   = cescd_pkg::ModeText;
        acc_d    = '0;
        cnt_d    = '0;
        allhex_d = 1'b1;
        unique case (c)
          cescd_pkg::ChA: begin
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail_byte  = cescd_pkg::CtlBell;
          end
          cescd_pkg::ChB: begin
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail_byte  = cescd_pkg::CtlBack;
          end
          cescd_pkg::ChF: begin
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail_byte  = cescd_pkg::CtlFeed;
          end
          cescd_pkg::ChN: begin
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail_byte  = cescd_pkg::CtlNewline;
          end
          cescd_pkg::ChR: begin
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail_byte  = cescd_pkg::CtlReturn;
          end
          cescd_pkg::ChT: begin
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail_byte  = cescd_pkg::CtlTab;
          end
          cescd_pkg::ChV: begin
            cmd_o.tail_valid = 1'b1;
            cmd_o.tail_byte  = cescd_pkg::CtlVtab;
          end
          cescd_pkg::ChX:      mode_d = cescd_pkg::ModeHex;
          cescd_pkg::ChLowerU: mode_d = cescd_pkg::ModeU4;
          cescd_pkg::ChUpperU: mode_d = cescd_pkg::ModeU8;
          default: begin
            if (is_oct) begin
              mode_d = cescd_pkg::ModeOct;
              acc_d  = {29'b0, c[2:0]};
              cnt_d  = 4'd1;
            end else begin
              cmd_o.tail_valid = 1'b1;
            end
          end
        endcase
      end
      cescd_pkg::ModeOct: begin
        if (is_oct) begin
          acc_n = {acc_q[28:0], c[2:0]};
          if (cnt_n >= cescd_pkg::OctDigits) begin
            cmd_o.code_valid = 1'b1;
            cmd_o.code_small = 1'b1;
            cmd_o.code_value = acc_n;
            mode_d   = cescd_pkg::ModeText;
            acc_d    = '0;
            cnt_d    = '0;
            allhex_d = 1'b1;
          end else begin
            acc_d = acc_n;
            cnt_d = cnt_n;
          end
        end else begin
          cmd_o.code_valid = 1'b1;
          cmd_o.code_small = 1'b1;
          mode_d   = cescd_pkg::ModeText;
          acc_d    = '0;
          cnt_d    = '0;
          allhex_d = 1'b1;
          do_text  = 1'b1;
        end
      end
      cescd_pkg::ModeHex: begin
        if (hexd[4]) begin
          // The gathered value saturates rather than wrapping.
          acc_d = (|acc_q[31:28]) ? '1 : {acc_q[27:0], hexd[3:0]};
          if (cnt_q < cescd_pkg::MaxHexCount) begin
            cnt_d = cnt_n;
          end
        end else begin
          cmd_o.code_valid = (cnt_q != '0);
          cmd_o.code_small = 1'b1;
          mode_d   = cescd_pkg::ModeText;
          acc_d    = '0;
          cnt_d    = '0;
          allhex_d = 1'b1;
          do_text  = 1'b1;
        end
      end
      cescd_pkg::ModeU4, cescd_pkg::ModeU8: begin
        acc_n    = hexd[4] ? {acc_q[27:0], hexd[3:0]} : acc_q;
        allhex_n = allhex_q & hexd[4];
        if (((mode_q == cescd_pkg::ModeU4) && (cnt_n >= cescd_pkg::U4Digits)) ||
            ((mode_q == cescd_pkg::ModeU8) && (cnt_n >= cescd_pkg::U8Digits))) begin
          cmd_o.code_valid = allhex_n;
          cmd_o.code_value = acc_n;
          mode_d   = cescd_pkg::ModeText;
          acc_d    = '0;
          cnt_d    = '0;
          allhex_d = 1'b1;
        end else begin
          acc_d    = acc_n;
          cnt_d    = cnt_n;
          allhex_d = allhex_n;
        end
      end
      default: begin
        mode_d  = cescd_pkg::ModeText;
        do_text = 1'b1;
      end
    endcase

    if (do_text) begin
      if (c == cescd_pkg::ChBackslash) begin
        mode_d = cescd_pkg::ModeEsc;
      end else begin
        cmd_o.tail_valid = 1'b1;
      end
    end

    // At the end of the string an open octal or hex run is flushed and the
    // parser returns to plain text.
    if (item_i.end_of_string) begin
      if ((mode_d == cescd_pkg::ModeOct) ||
          ((mode_d == cescd_pkg::ModeHex) && (cnt_d != '0))) begin
        cmd_o.code_valid = 1'b1;
        cmd_o.code_small = 1'b1;
        cmd_o.code_value = acc_d;
      end
      mode_d   = cescd_pkg::ModeText;
      acc_d    = '0;
      cnt_d    = '0;
      allhex_d = 1'b1;
    end
  end

  assign enq_o = accept_i & (cmd_o.code_valid | cmd_o.tail_valid | item_i.end_of_string);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= cescd_pkg::ModeText;
      acc_q    <= '0;
      cnt_q    <= '0;
      allhex_q <= 1'b1;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      allhex_q <= allhex_d;
    end
  end

endmodule

// ----- rtl/core/cescd_fifo.sv -----
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module cescd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cescd_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output cescd_pkg::cmd_t data_o,
  output logic            empty_o
);

  localparam int unsigned Depth  = cescd_pkg::CmdQueueDepth;
  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  cescd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CountW-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CountW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/cescd_back.sv -----
// Back part: expands commands into UTF-8 bytes and presents one result per cycle while popped.
`timescale 1ns / 1ps
module cescd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  cescd_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output cescd_pkg::out_item_t item_o
);

  logic       seq_valid_q;
  logic [7:0] bytes_q [4];
  logic [1:0] n_q;     // index of the final byte of the sequence
  logic [1:0] idx_q;
  logic       has_q;
  logic       last_q;

  logic        load;
  logic        done;
  logic [20:0] u;
  logic [2:0]  code_len;
  logic [2:0]  total;
  logic [7:0]  cb [4];
  logic [7:0]  seq [4];

  assign done      = pop_i & seq_valid_q & (idx_q == n_q);
  assign load      = cmd_valid_i & (~seq_valid_q | done);
  assign cmd_pop_o = load;

  // Clamp to a valid code point and encode it.
  always_comb begin
    if (cmd_i.code_small) begin
      u = (|cmd_i.code_value[31:7]) ? cescd_pkg::Replacement : cmd_i.code_value[20:0];
    end else if ((cmd_i.code_value[31:11] == 21'h00001B) ||
                 (cmd_i.code_value > cescd_pkg::MaxCode)) begin
      u = cescd_pkg::Replacement;
    end else begin
      u = cmd_i.code_value[20:0];
    end

    cb[0] = u[7:0];
    cb[1] = 8'h00;
    cb[2] = 8'h00;
    cb[3] = 8'h00;
    if (u < 21'h80) begin
      code_len = 3'd1;
    end else if (u < 21'h800) begin
      code_len = 3'd2;
      cb[0] = {3'b110, u[10:6]};
      cb[1] = {2'b10, u[5:0]};
    end else if (u < 21'h10000) begin
      code_len = 3'd3;
      cb[0] = {4'b1110, u[15:12]};
      cb[1] = {2'b10, u[11:6]};
      cb[2] = {2'b10, u[5:0]};
    end else begin
      code_len = 3'd4;
      cb[0] = {5'b11110, u[20:18]};
      cb[1] = {2'b10, u[17:12]};
      cb[2] = {2'b10, u[11:6]};
      cb[3] = {2'b10, u[5:0]};
    end
    if (!cmd_i.code_valid) begin
      code_len = 3'd0;
    end

    total = code_len + {2'b0, cmd_i.tail_valid};
    for (int k = 0; k < 4; k++) begin
      seq[k] = (3'(k) < code_len) ? cb[k] : cmd_i.tail_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < 4; k++) begin
        bytes_q[k] <= seq[k];
      end
      n_q    <= (total == '0) ? 2'd0 : 2'(total - 3'd1);
      has_q  <= (total != '0);
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      seq_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (done) begin
      seq_valid_q <= 1'b0;
    end else if (pop_i && seq_valid_q) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  assign empty_o               = ~seq_valid_q;
  assign item_o.out_byte       = has_q ? bytes_q[idx_q] : 8'h00;
  assign item_o.has_byte       = has_q;
  assign item_o.last_of_string = last_q & (idx_q == n_q);

`ifndef NO_ASSERTIONS
  // A sequence with no bytes is a lone end mark.
  a_mark_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_valid_q && !has_q) |-> (n_q == 2'd0 && last_q))
    else $error("end mark sequence longer than one result");

  // The byte index never runs past the end of the sequence.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_q |-> (idx_q <= n_q))
    else $error("byte index past end of sequence");

  // A freshly loaded sequence starts at its first byte.
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (seq_valid_q && idx_q == 2'd0))
    else $error("loaded sequence does not start at first byte");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the C escape decoder with a UTF-8 predicting scoreboard.
`timescale 1ns / 1ps
module testbench;

  // Tracks the parser state of the decoder and keeps the decoded bytes still due.
  class escape_scoreboard;
    cescd_pkg::out_item_t decoded_q[$];
    logic [7:0]           step_bytes[$];
    cescd_pkg::mode_e     mode;
    logic [31:0]          acc;
    logic [3:0]           count;
    bit                   all_hex;
    int                   errors;

    function new();
      errors = 0;
      to_text();
    endfunction

    function void to_text();
      mode = cescd_pkg::ModeText;
      acc = '0;
      count = '0;
      all_hex = 1'b1;
    endfunction

    function int digit_value(logic [7:0] c);
      if (c >= cescd_pkg::ChZero && c <= cescd_pkg::ChNine) begin
        return int'(c - cescd_pkg::ChZero);
      end
      if (c >= cescd_pkg::ChA && c <= cescd_pkg::ChF) begin
        return int'(c - cescd_pkg::ChA) + 10;
      end
      if (c >= cescd_pkg::ChUpperA && c <= cescd_pkg::ChUpperF) begin
        return int'(c - cescd_pkg::ChUpperA) + 10;
      end
      return -1;
    endfunction

    function void emit_code(logic [31:0] u);
      logic [31:0] cp;
      cp = u;
      if ((cp >= 32'hD800 && cp <= 32'hDFFF) || cp > cescd_pkg::MaxCode) begin
        cp = {11'b0, cescd_pkg::Replacement};
      end
      if (cp < 32'h80) begin
        step_bytes.push_back(cp[7:0]);
      end else if (cp < 32'h800) begin
        step_bytes.push_back({3'b110, cp[10:6]});
        step_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 32'h10000) begin
        step_bytes.push_back({4'b1110, cp[15:12]});
        step_bytes.push_back({2'b10, cp[11:6]});
        step_bytes.push_back({2'b10, cp[5:0]});
      end else begin
        step_bytes.push_back({5'b11110, cp[20:18]});
        step_bytes.push_back({2'b10, cp[17:12]});
        step_bytes.push_back({2'b10, cp[11:6]});
        step_bytes.push_back({2'b10, cp[5:0]});
      end
    endfunction

    // Octal and \x values only stand for themselves below 0x80.
    function void emit_small(logic [31:0] v);
      emit_code(v < 32'h80 ? v : {11'b0, cescd_pkg::Replacement});
    endfunction

    function void text_char(logic [7:0] c);
      if (c == cescd_pkg::ChBackslash) mode = cescd_pkg::ModeEsc;
      else step_bytes.push_back(c);
    endfunction

    function void escape_char(logic [7:0] c);
      to_text();
      case (c)
        cescd_pkg::ChA: step_bytes.push_back(cescd_pkg::CtlBell);
        cescd_pkg::ChB: step_bytes.push_back(cescd_pkg::CtlBack);
        cescd_pkg::ChF: step_bytes.push_back(cescd_pkg::CtlFeed);
        cescd_pkg::ChN: step_bytes.push_back(cescd_pkg::CtlNewline);
        cescd_pkg::ChR: step_bytes.push_back(cescd_pkg::CtlReturn);
        cescd_pkg::ChT: step_bytes.push_back(cescd_pkg::CtlTab);
        cescd_pkg::ChV: step_bytes.push_back(cescd_pkg::CtlVtab);
        cescd_pkg::ChX: mode = cescd_pkg::ModeHex;
        cescd_pkg::ChLowerU: mode = cescd_pkg::ModeU4;
        cescd_pkg::ChUpperU: mode = cescd_pkg::ModeU8;
        default: begin
          if (c >= cescd_pkg::ChZero && c <= cescd_pkg::ChSeven) begin
            mode = cescd_pkg::ModeOct;
            acc = {29'b0, c[2:0]};
            count = 4'd1;
          end else begin
            step_bytes.push_back(c);
          end
        end
      endcase
    endfunction

    function void octal_char(logic [7:0] c);
      if (c >= cescd_pkg::ChZero && c <= cescd_pkg::ChSeven) begin
        acc = (acc << 3) + {29'b0, c[2:0]};
        count++;
        if (count >= cescd_pkg::OctDigits) begin
          emit_small(acc);
          to_text();
        end
      end else begin
        emit_small(acc);
        to_text();
        text_char(c);
      end
    endfunction

    function void hex_run_char(logic [7:0] c);
      int d;
      d = digit_value(c);
      if (d >= 0) begin
        // The gathered value sticks at all ones instead of wrapping.
        if (acc > 32'h0FFFFFFF) acc = '1;
        else acc = (acc << 4) | {28'b0, d[3:0]};
        if (count < cescd_pkg::MaxHexCount) count++;
      end else begin
        if (count != 4'd0) emit_small(acc);
        to_text();
        text_char(c);
      end
    endfunction

    function void unicode_char(logic [7:0] c, logic [3:0] need);
      int d;
      d = digit_value(c);
      if (d >= 0) acc = (acc << 4) | {28'b0, d[3:0]};
      else all_hex = 1'b0;
      count++;
      if (count >= need) begin
        if (all_hex) emit_code(acc);
        to_text();
      end
    endfunction

    function void note_input(cescd_pkg::in_item_t it);
      cescd_pkg::out_item_t r;
      step_bytes.delete();
      case (mode)
        cescd_pkg::ModeEsc: escape_char(it.in_byte);
        cescd_pkg::ModeOct: octal_char(it.in_byte);
        cescd_pkg::ModeHex: hex_run_char(it.in_byte);
        cescd_pkg::ModeU4:  unicode_char(it.in_byte, cescd_pkg::U4Digits);
        cescd_pkg::ModeU8:  unicode_char(it.in_byte, cescd_pkg::U8Digits);
        default: begin
          mode = cescd_pkg::ModeText;
          text_char(it.in_byte);
        end
      endcase
      if (it.end_of_string) begin
        if (mode == cescd_pkg::ModeOct) emit_small(acc);
        else if (mode == cescd_pkg::ModeHex && count != 4'd0) emit_small(acc);
        to_text();
      end
      if (it.end_of_string && step_bytes.size() == 0) begin
        r = '0;
        r.last_of_string = 1'b1;
        decoded_q.push_back(r);
      end
      foreach (step_bytes[k]) begin
        r.out_byte = step_bytes[k];
        r.has_byte = 1'b1;
        r.last_of_string = it.end_of_string && (k == step_bytes.size() - 1);
        decoded_q.push_back(r);
      end
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s: expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_result(cescd_pkg::out_item_t got);
      cescd_pkg::out_item_t want;
      if (decoded_q.size() == 0) begin
        report("unexpected result", 8'h00, got.out_byte);
        return;
      end
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
      if (got.has_byte !== want.has_byte) begin
        report("has_byte", {7'b0, want.has_byte}, {7'b0, got.has_byte});
      end
      if (got.last_of_string !== want.last_of_string) begin
        report("last_of_string", {7'b0, want.last_of_string}, {7'b0, got.last_of_string});
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 pop = 1'b0;
  logic                 full;
  logic                 empty;
  cescd_pkg::in_item_t  in_item = '0;
  cescd_pkg::out_item_t out_item;

  bit         sender_idles = 1'b1;
  bit         receiver_stalls = 1'b1;
  logic [7:0] string_bytes[$];
  escape_scoreboard board = new();

  c_escape_decoder dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: pops most cycles, stalls now and then while receiver_stalls is set.
  initial begin
    forever begin
      pop <= !(receiver_stalls && $urandom_range(99) < 14);
      @(posedge clk_i);
      if (rst_ni && pop && !empty) board.check_result(out_item);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eos);
    cescd_pkg::in_item_t it;
    it.in_byte = b;
    it.end_of_string = eos;
    while (sender_idles && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_input(it);
  endtask

  task automatic send_string();
    foreach (string_bytes[i]) send_item(string_bytes[i], i == string_bytes.size() - 1);
    string_bytes.delete();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (board.decoded_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) string_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] base;
    if (d < 4'd10) return cescd_pkg::ChZero + {4'b0, d};
    base = $urandom_range(1) ? cescd_pkg::ChUpperA : cescd_pkg::ChA;
    return base + {4'b0, d} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (board.digit_value(b) >= 0);
    return b;
  endfunction

  function automatic void add_hex(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) string_bytes.push_back(hex_char(v[4*i +: 4]));
  endfunction

  // Appends one random token: plain text, an escape of some kind, or raw noise.
  function automatic void add_token();
    int          kind;
    int          n;
    int          start;
    logic [7:0]  c;
    logic [31:0] v;
    kind = $urandom_range(99);
    if (kind < 20) begin
      c = 8'($urandom_range(255));
      string_bytes.push_back(c == cescd_pkg::ChBackslash ? cescd_pkg::ChZero : c);
    end else if (kind < 35) begin
      case ($urandom_range(9))
        0: c = cescd_pkg::ChA;
        1: c = cescd_pkg::ChB;
        2: c = cescd_pkg::ChF;
        3: c = cescd_pkg::ChN;
        4: c = cescd_pkg::ChR;
        5: c = cescd_pkg::ChT;
        6: c = cescd_pkg::ChV;
        default: c = 8'($urandom_range(255));
      endcase
      string_bytes.push_back(cescd_pkg::ChBackslash);
      string_bytes.push_back(c);
    end else if (kind < 48) begin
      string_bytes.push_back(cescd_pkg::ChBackslash);
      repeat ($urandom_range(1, 3)) begin
        string_bytes.push_back(cescd_pkg::ChZero + 8'($urandom_range(7)));
      end
    end else if (kind < 62) begin
      string_bytes.push_back(cescd_pkg::ChBackslash);
      string_bytes.push_back(cescd_pkg::ChX);
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
      repeat (n) string_bytes.push_back(hex_char(4'($urandom_range(15))));
    end else if (kind < 88) begin
      string_bytes.push_back(cescd_pkg::ChBackslash);
      if (kind < 75) begin
        string_bytes.push_back(cescd_pkg::ChLowerU);
        n = 4;
        v = $urandom_range(16'hFFFF);
      end else begin
        string_bytes.push_back(cescd_pkg::ChUpperU);
        n = 8;
        case ($urandom_range(3))
          0: v = $urandom_range(32'h7F);
          1: v = $urandom_range(32'h10FFFF);
          2: v = $urandom_range(32'h10000, 32'h10FFFF);
          default: v = $urandom;
        endcase
      end
      start = string_bytes.size();
      add_hex(v, n);
      if ($urandom_range(6) == 0) string_bytes[start + $urandom_range(n - 1)] = non_hex_byte();
    end else begin
      string_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    int random_items;
    int len;
    bit drained;
    random_items = 0;
    drained = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    string_bytes.push_back(8'h00);
    string_bytes.push_back(8'hFF);
    send_string();
    add_text("\\U0010FFFF");
    send_string();
    add_text("\\uD800");
    send_string();
    add_text("\\17");
    send_string();
    add_text("\\x");
    send_string();
    add_text("\\");
    send_string();
    wait_drained();

    while (random_items < 250) begin
      repeat ($urandom_range(1, 8)) add_token();
      // Cut some strings short so escapes get interrupted by the end mark.
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, string_bytes.size());
        while (string_bytes.size() > len) void'(string_bytes.pop_back());
      end
      sender_idles = !(random_items >= 90 && random_items < 160);
      receiver_stalls = sender_idles;
      random_items += string_bytes.size();
      send_string();
      if (!drained && random_items >= 120) begin
        wait_drained();
        drained = 1'b1;
      end
    end

    push <= 1'b0;
    while (board.decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.decoded_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
